FILE: rtl/nldm_pkg.sv
// Package: shared types, constants and codes for the table lookup core.
`default_nettype none
package nldm_pkg;
    localparam int MAX_POINTS_DEF = 8;
    localparam int AXIS_BITS_DEF  = 16;
    localparam int ENTRY_BITS_DEF = 24;
    localparam int CFG_BITS       = 4;
    localparam int FUNC_BITS      = 2;
    localparam int STATUS_BITS    = 2;

    localparam logic [FUNC_BITS-1:0] FUNC_ROW   = 2'd0;
    localparam logic [FUNC_BITS-1:0] FUNC_COL   = 2'd1;
    localparam logic [FUNC_BITS-1:0] FUNC_ENTRY = 2'd2;
    localparam logic [FUNC_BITS-1:0] FUNC_QUERY = 2'd3;

    localparam logic [STATUS_BITS-1:0] ST_WRITE = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_OK    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_OOR   = 2'd2;

    localparam logic CFG_ROW = 1'b0;
    localparam logic CFG_COL = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE, S_WRITE, S_SEARCH, S_CORNER, S_MUL, S_ACC, S_DIV, S_DONE, S_OOR
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the word
        logic write;      // perform store write
        logic srch_init;
        logic srch_step;
        logic crn_rd;     // issue corner read
        logic mul;        // multiply weights / entry
        logic acc;        // accumulate product
        logic div_init;
        logic div_step;
        logic done_ok;
        logic done_oor;
        logic done_wr;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_query;
        logic srch_done;
        logic srch_fail;
        logic last_corner;
        logic div_done;
    } t_stat;
endpackage
`default_nettype wire

FILE: rtl/nldm_ram.sv
// Generic single-port-write RAM with registered read.
`default_nettype none
module nldm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/nldm_ctrl.sv
// Controller state machine for the lookup core.
`default_nettype none
module nldm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output logic               o_busy,
    input  wire nldm_pkg::t_stat i_stat,
    output nldm_pkg::t_cmd     o_cmd
);
    import nldm_pkg::*;
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_start) n_state = S_WRITE;
            S_WRITE:  n_state = i_stat.is_query ? S_SEARCH : S_DONE;
            S_SEARCH: begin
                if (i_stat.srch_fail)      n_state = S_OOR;
                else if (i_stat.srch_done) n_state = S_CORNER;
            end
            S_CORNER: n_state = S_MUL;
            S_MUL:    n_state = S_ACC;
            S_ACC:    n_state = i_stat.last_corner ? S_DIV : S_CORNER;
            S_DIV:    if (i_stat.div_done) n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            S_OOR:    n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_busy = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE:   begin
                o_cmd.load = i_start;
            end
            S_WRITE:  begin
                o_cmd.write = !i_stat.is_query;
                o_cmd.srch_init = i_stat.is_query;
            end
            S_SEARCH: o_cmd.srch_step = 1'b1;
            S_CORNER: o_cmd.crn_rd = 1'b1;
            S_MUL:    o_cmd.mul = 1'b1;
            S_ACC:    begin
                o_cmd.acc = 1'b1;
                o_cmd.div_init = i_stat.last_corner;
            end
            S_DIV:    o_cmd.div_step = 1'b1;
            S_DONE:   begin
                o_cmd.done_ok = i_stat.is_query;
                o_cmd.done_wr = !i_stat.is_query;
            end
            S_OOR:    o_cmd.done_oor = 1'b1;
            default:  ;
        endcase
    end
endmodule
`default_nettype wire

FILE: rtl/nldm_dp.sv
// Datapath: axis stores, entry RAM, bracket search, MAC and serial divider.
`default_nettype none
module nldm_dp #(
    parameter int AXIS_BITS  = nldm_pkg::AXIS_BITS_DEF,
    parameter int ENTRY_BITS = nldm_pkg::ENTRY_BITS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [nldm_pkg::CFG_BITS-1:0] i_row_points,
    input  wire logic [nldm_pkg::CFG_BITS-1:0] i_col_points,
    input  wire logic [nldm_pkg::FUNC_BITS-1:0] i_func,
    input  wire logic [2:0]                    i_row_index,
    input  wire logic [2:0]                    i_col_index,
    input  wire logic [AXIS_BITS-1:0]          i_axis_value,
    input  wire logic [ENTRY_BITS-1:0]         i_entry_value,
    input  wire logic [AXIS_BITS-1:0]          i_query_transition,
    input  wire logic [AXIS_BITS-1:0]          i_query_load,
    input  wire nldm_pkg::t_cmd                i_cmd,
    output nldm_pkg::t_stat                    o_stat,
    output logic                               o_valid,
    output logic [ENTRY_BITS-1:0]              o_result_value,
    output logic [nldm_pkg::STATUS_BITS-1:0]   o_status
);
    import nldm_pkg::*;
    localparam int MAX_POINTS = MAX_POINTS_DEF;
    localparam int IB = $clog2(MAX_POINTS);
    localparam int AB = 2 * IB;
    localparam int WB = 2 * AXIS_BITS;           // weight / area width
    localparam int PB = WB + ENTRY_BITS;         // product width
    localparam int SB = PB + 2;                  // sum of four
    localparam int CB = $clog2(SB + 1);
    localparam int PCB = $clog2(MAX_POINTS + 1);

    logic [FUNC_BITS-1:0]  r_func;
    logic [2:0]            r_ri, r_ci;
    logic [AXIS_BITS-1:0]  r_av, r_x, r_y;
    logic [ENTRY_BITS-1:0] r_ev;
    logic [AXIS_BITS-1:0]  r_raxis [MAX_POINTS];
    logic [AXIS_BITS-1:0]  r_caxis [MAX_POINTS];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func; r_ri <= i_row_index; r_ci <= i_col_index;
            r_av <= i_axis_value; r_ev <= i_entry_value;
            r_x <= i_query_transition; r_y <= i_query_load;
        end
    end

    logic ri_ok, ci_ok;
    assign ri_ok = ({29'd0, r_ri} < MAX_POINTS);
    assign ci_ok = ({29'd0, r_ci} < MAX_POINTS);

    always_ff @(posedge i_clk) begin
        if (i_cmd.write && r_func == FUNC_ROW && ri_ok) r_raxis[r_ri[IB-1:0]] <= r_av;
        if (i_cmd.write && r_func == FUNC_COL && ci_ok) r_caxis[r_ci[IB-1:0]] <= r_av;
    end

    function automatic logic [PCB-1:0] clampn(input logic [CFG_BITS-1:0] n);
        if (n < 4'd2) return PCB'(2);
        if ({28'd0, n} > MAX_POINTS) return PCB'(MAX_POINTS);
        return PCB'(n);
    endfunction

    // bracket search: one index a cycle on both axes
    logic [PCB-1:0] r_si, r_sj;
    logic           r_fi, r_fj;
    logic [IB-1:0]  r_bi, r_bj;
    logic [AXIS_BITS-1:0] r_ax, r_dx, r_ay, r_dy;
    logic [PCB-1:0] np_r, np_c;
    logic i_end, j_end, i_hit, j_hit;
    logic [AXIS_BITS-1:0] rlo, rhi, clo, chi;
    assign np_r = clampn(i_row_points);
    assign np_c = clampn(i_col_points);
    assign i_end = (r_si + PCB'(1) >= np_r);
    assign j_end = (r_sj + PCB'(1) >= np_c);
    assign rlo = r_raxis[r_si[IB-1:0]];
    assign rhi = r_raxis[IB'(r_si + PCB'(1))];
    assign clo = r_caxis[r_sj[IB-1:0]];
    assign chi = r_caxis[IB'(r_sj + PCB'(1))];
    assign i_hit = !i_end && rlo <= r_x && r_x <= rhi;
    assign j_hit = !j_end && clo <= r_y && r_y <= chi;

    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_init) begin
            r_si <= '0; r_sj <= '0; r_fi <= 1'b0; r_fj <= 1'b0;
        end else if (i_cmd.srch_step) begin
            if (!r_fi && !i_end) begin
                if (i_hit) begin
                    r_fi <= 1'b1; r_bi <= r_si[IB-1:0];
                    r_ax <= r_x - rlo; r_dx <= (rhi == rlo) ? AXIS_BITS'(1) : rhi - rlo;
                end else r_si <= r_si + PCB'(1);
            end
            if (!r_fj && !j_end) begin
                if (j_hit) begin
                    r_fj <= 1'b1; r_bj <= r_sj[IB-1:0];
                    r_ay <= r_y - clo; r_dy <= (chi == clo) ? AXIS_BITS'(1) : chi - clo;
                end else r_sj <= r_sj + PCB'(1);
            end
        end
    end

    assign o_stat.is_query  = (r_func == FUNC_QUERY);
    assign o_stat.srch_done = r_fi && r_fj;
    assign o_stat.srch_fail = (!r_fi && i_end) || (!r_fj && j_end);

    // corner sequencing and entry RAM
    logic [1:0] r_k;
    logic [AB-1:0] waddr, raddr;
    logic [ENTRY_BITS-1:0] rdata;
    logic [IB-1:0] ci_row, ci_col;
    assign ci_row = r_bi + IB'(r_k[1]);
    assign ci_col = r_bj + IB'(r_k[0]);
    assign waddr = {r_ri[IB-1:0], r_ci[IB-1:0]};
    assign raddr = {ci_row, ci_col};
    assign o_stat.last_corner = (r_k == 2'd3);

    nldm_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_POINTS * MAX_POINTS)) u_tab (
        .i_clk  (i_clk),
        .i_we   (i_cmd.write && r_func == FUNC_ENTRY && ri_ok && ci_ok),
        .i_waddr(waddr),
        .i_wdata(r_ev),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    // weight for the corner: row part times column part
    logic [AXIS_BITS-1:0] wr, wc;
    assign wr = r_k[1] ? r_ax : r_dx - r_ax;
    assign wc = r_k[0] ? r_ay : r_dy - r_ay;

    logic [WB-1:0] r_w, r_area;
    logic [PB-1:0] r_prod;
    logic [SB-1:0] r_sum;
    always_ff @(posedge i_clk) begin
        if (i_cmd.srch_init) r_k <= '0;
        if (i_cmd.crn_rd) begin
            r_w <= WB'(wr) * WB'(wc);
            r_area <= WB'(r_dx) * WB'(r_dy);
        end
        if (i_cmd.mul) r_prod <= PB'(r_w) * PB'(rdata);
        if (i_cmd.acc) begin
            r_sum <= ((r_k == 2'd0) ? SB'(0) : r_sum) + SB'(r_prod);
            r_k <= r_k + 2'd1;
        end
    end

    // restoring divider, one quotient bit a cycle
    logic [SB-1:0] r_num, r_q;
    logic [WB:0]   r_rem;
    logic [CB-1:0] r_cnt;
    logic [WB:0]   trial;
    assign trial = {r_rem[WB-1:0], r_num[SB-1]};
    assign o_stat.div_done = (r_cnt == CB'(SB));
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_init) begin
            r_num <= r_sum + SB'(r_prod); r_rem <= '0; r_q <= '0; r_cnt <= '0;
        end else if (i_cmd.div_step && !o_stat.div_done) begin
            r_num <= r_num << 1;
            r_cnt <= r_cnt + CB'(1);
            if (trial >= {1'b0, r_area}) begin
                r_rem <= trial - {1'b0, r_area}; r_q <= {r_q[SB-2:0], 1'b1};
            end else begin
                r_rem <= trial; r_q <= {r_q[SB-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else o_valid <= i_cmd.done_ok || i_cmd.done_oor || i_cmd.done_wr;
        if (i_cmd.done_ok) begin
            o_result_value <= r_q[ENTRY_BITS-1:0]; o_status <= ST_OK;
        end else if (i_cmd.done_oor) begin
            o_result_value <= '0; o_status <= ST_OOR;
        end else if (i_cmd.done_wr) begin
            o_result_value <= '0; o_status <= ST_WRITE;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/nldm_table_bilinear_lookup_core.sv
// Top level of the NLDM table lookup core with bilinear interpolation.
//  channel  | ports                                   | handshake
//  command  | start, i_func .. i_query_load            | start & !busy
//  result   | o_result_value, o_status                 | o_done, one cycle
//  config   | i_cfg_we, i_cfg_index, i_cfg_data        | write enable
// A write passes the write and done states before it strobes o_done. A query
// passes a decode state, the bracket search, the corner, multiply and
// accumulate states for each of the four corners, the serial divider over
// SB = 2*AXIS_BITS+ENTRY_BITS+2 quotient bits (58 by default) and a final done
// state before o_done; out of range it goes from the search to the out-of-range
// state instead. Busy is low in the o_done cycle. Reset (synchronous, active low)
// idles the controller and sets both point counts to MAX_POINTS; the receiver cannot stall the result.
`default_nettype none
module nldm_table_bilinear_lookup_core #(
    parameter int AXIS_BITS  = nldm_pkg::AXIS_BITS_DEF,
    parameter int ENTRY_BITS = nldm_pkg::ENTRY_BITS_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic                           i_cfg_index,
    input  wire logic [nldm_pkg::CFG_BITS-1:0]  i_cfg_data,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [nldm_pkg::FUNC_BITS-1:0] i_func,
    input  wire logic [2:0]                     i_row_index,
    input  wire logic [2:0]                     i_col_index,
    input  wire logic [AXIS_BITS-1:0]           i_axis_value,
    input  wire logic [ENTRY_BITS-1:0]          i_entry_value,
    input  wire logic [AXIS_BITS-1:0]           i_query_transition,
    input  wire logic [AXIS_BITS-1:0]           i_query_load,
    output logic                                o_done,
    output logic [ENTRY_BITS-1:0]               o_result_value,
    output logic [nldm_pkg::STATUS_BITS-1:0]    o_status
);
    import nldm_pkg::*;
    localparam int MAX_POINTS = MAX_POINTS_DEF;
    logic [CFG_BITS-1:0] r_row_points, r_col_points;
    t_cmd  cmd;
    t_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_points <= CFG_BITS'(MAX_POINTS);
            r_col_points <= CFG_BITS'(MAX_POINTS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROW: r_row_points <= i_cfg_data;
                CFG_COL: r_col_points <= i_cfg_data;
                default: ;
            endcase
        end
    end

    nldm_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .o_busy(busy),
        .i_stat(stat), .o_cmd(cmd)
    );

    nldm_dp #(.AXIS_BITS(AXIS_BITS), .ENTRY_BITS(ENTRY_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_row_points(r_row_points), .i_col_points(r_col_points),
        .i_func(i_func), .i_row_index(i_row_index), .i_col_index(i_col_index),
        .i_axis_value(i_axis_value), .i_entry_value(i_entry_value),
        .i_query_transition(i_query_transition), .i_query_load(i_query_load),
        .i_cmd(cmd), .o_stat(stat), .o_valid(o_done),
        .o_result_value(o_result_value), .o_status(o_status)
    );

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe held");
    a_oor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status == ST_OOR) |-> o_result_value == '0)
        else $error("out of range result not zero");
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy) else $error("accepted word not busy");
`endif
endmodule
`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the NLDM table bilinear lookup core.
`timescale 1ns / 100ps
module testbench;
    import nldm_pkg::*;

    typedef struct {
        logic [1:0]  func;
        logic [2:0]  row_idx;
        logic [2:0]  col_idx;
        logic [15:0] axis_val;
        logic [23:0] entry_val;
        logic [15:0] q_tran;
        logic [15:0] q_load;
    } t_word;

    typedef struct {
        logic [23:0] value;
        logic [1:0]  status;
    } t_answer;

    localparam int STALL_LIMIT = 4000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_index = 1'b0;
    logic [3:0] i_cfg_data = 4'd0;
    logic start = 1'b0;
    logic busy;
    logic [1:0]  i_func = FUNC_ROW;
    logic [2:0]  i_row_index = 3'd0;
    logic [2:0]  i_col_index = 3'd0;
    logic [15:0] i_axis_value = 16'd0;
    logic [23:0] i_entry_value = 24'd0;
    logic [15:0] i_query_transition = 16'd0;
    logic [15:0] i_query_load = 16'd0;
    logic o_done;
    logic [23:0] o_result_value;
    logic [1:0]  o_status;

    nldm_table_bilinear_lookup_core DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .start(start), .busy(busy),
        .i_func(i_func), .i_row_index(i_row_index), .i_col_index(i_col_index),
        .i_axis_value(i_axis_value), .i_entry_value(i_entry_value),
        .i_query_transition(i_query_transition), .i_query_load(i_query_load),
        .o_done(o_done), .o_result_value(o_result_value), .o_status(o_status)
    );

    always #4 i_clk = ~i_clk;

    t_word   pending_words[$];
    t_answer expected_answers[$];
    int      errors = 0;
    bit      no_gaps = 0;

    // predictor copy of the block state
    logic [3:0]  row_count = 4'd8;
    logic [3:0]  col_count = 4'd8;
    logic [15:0] row_axis_m[8];
    logic [15:0] col_axis_m[8];
    logic [23:0] table_m[64];

    // stimulus-side view of what has been loaded
    logic [15:0] plan_row[8];
    logic [15:0] plan_col[8];
    int          eff_rows = 8;
    int          eff_cols = 8;

    function automatic int clamp_count(logic [3:0] n);
        if (n < 2) return 2;
        if (n > 8) return 8;
        return n;
    endfunction

    function automatic bit bracket(input logic [15:0] p[8], input int n,
                                   input logic [15:0] x, output int lo,
                                   output logic [63:0] off, output logic [63:0] span);
        for (int i = 0; i + 1 < n; i++) begin
            if (p[i] <= x && x <= p[i+1]) begin
                lo = i;
                off = x - p[i];
                span = p[i+1] - p[i];
                if (span == 0) span = 1;
                return 1;
            end
        end
        return 0;
    endfunction

    function automatic t_answer lookup_step(t_word w);
        t_answer a;
        int i, j;
        logic [63:0] ax, dx, ay, dy, bx, by;
        logic [127:0] acc;
        a.value = 24'd0;
        a.status = ST_WRITE;
        case (w.func)
            FUNC_ROW:   row_axis_m[w.row_idx] = w.axis_val;
            FUNC_COL:   col_axis_m[w.col_idx] = w.axis_val;
            FUNC_ENTRY: table_m[w.row_idx*8 + w.col_idx] = w.entry_val;
            default: begin
                if (!bracket(row_axis_m, clamp_count(row_count), w.q_tran, i, ax, dx) ||
                    !bracket(col_axis_m, clamp_count(col_count), w.q_load, j, ay, dy)) begin
                    a.status = ST_OOR;
                end else begin
                    bx = dx - ax;
                    by = dy - ay;
                    acc = 128'(bx*by) * table_m[i*8 + j]
                        + 128'(bx*ay) * table_m[i*8 + j + 1]
                        + 128'(ax*by) * table_m[(i+1)*8 + j]
                        + 128'(ax*ay) * table_m[(i+1)*8 + j + 1];
                    acc = acc / 128'(dx*dy);
                    a.value = acc[23:0];
                    a.status = ST_OK;
                end
            end
        endcase
        return a;
    endfunction

    // driver
    int gap_left = 0;
    always @(posedge i_clk) begin
        t_word w;
        bit drive_next;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            drive_next = 0;
            if (start && !busy) begin
                w.func = i_func; w.row_idx = i_row_index; w.col_idx = i_col_index;
                w.axis_val = i_axis_value; w.entry_val = i_entry_value;
                w.q_tran = i_query_transition; w.q_load = i_query_load;
                expected_answers.insert(expected_answers.size(), lookup_step(w));
                drive_next = 1;
                if (!no_gaps) begin
                    case ($urandom_range(0, 19))
                        0:             gap_left = $urandom_range(20, 60);
                        1, 2, 3, 4, 5: gap_left = $urandom_range(1, 3);
                        default:       gap_left = 0;
                    endcase
                end
            end else if (!start) begin
                drive_next = 1;
            end
            if (drive_next) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_words.size() > 0) begin
                    w = pending_words.pop_front();
                    i_func <= w.func; i_row_index <= w.row_idx; i_col_index <= w.col_idx;
                    i_axis_value <= w.axis_val; i_entry_value <= w.entry_val;
                    i_query_transition <= w.q_tran; i_query_load <= w.q_load;
                    start <= 1'b1;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_answer e;
        if (i_rst_n && o_done) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: unexpected word value=%h status=%0d", $time,
                         o_result_value, o_status);
                errors++;
            end else begin
                e = expected_answers.pop_front();
                if (o_result_value !== e.value) begin
                    $display("%0t: value mismatch expected %h actual %h", $time,
                             e.value, o_result_value);
                    errors++;
                end
                if (o_status !== e.status) begin
                    $display("%0t: status mismatch expected %0d actual %0d", $time,
                             e.status, o_status);
                    errors++;
                end
            end
        end
    end

    // watchdog
    int stall_cycles = 0;
    always @(posedge i_clk) begin
        if ((start && !busy) || o_done || !i_rst_n) stall_cycles = 0;
        else stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic queue_word(logic [1:0] f, logic [2:0] r, logic [2:0] c,
                              logic [15:0] av, logic [23:0] ev,
                              logic [15:0] qt, logic [15:0] ql);
        t_word w;
        w.func = f; w.row_idx = r; w.col_idx = c;
        w.axis_val = av; w.entry_val = ev; w.q_tran = qt; w.q_load = ql;
        pending_words.insert(pending_words.size(), w);
    endtask

    task automatic write_point(logic [1:0] f, int k, logic [15:0] v);
        queue_word(f, 3'(k), 3'(k), v, 24'($urandom), 16'($urandom), 16'($urandom));
        if (f == FUNC_ROW) plan_row[k] = v;
        else plan_col[k] = v;
    endtask

    task automatic query(logic [15:0] t, logic [15:0] l);
        queue_word(FUNC_QUERY, 3'($urandom), 3'($urandom), 16'($urandom),
                   24'($urandom), t, l);
    endtask

    task automatic wait_idle;
        do @(posedge i_clk);
        while (pending_words.size() || start || expected_answers.size() || busy);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_counts(logic [3:0] r, logic [3:0] c);
        wait_idle();
        i_cfg_we <= 1'b1; i_cfg_index <= CFG_ROW; i_cfg_data <= r;
        @(posedge i_clk);
        i_cfg_index <= CFG_COL; i_cfg_data <= c;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        row_count = r; col_count = c;
        eff_rows = clamp_count(r); eff_cols = clamp_count(c);
    endtask

    // increasing axis, sometimes with equal neighbours and the range ends
    task automatic load_axis(logic [1:0] f, int n);
        int v, step;
        v = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 2000);
        for (int k = 0; k < 8; k++) begin
            if (k == n - 1 && $urandom_range(0, 2) == 0) v = 65535;
            if (k < n) write_point(f, k, 16'(v));
            step = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 60000 / n);
            v = (v + step > 65535) ? 65535 : v + step;
        end
    endtask

    task automatic load_table;
        logic [23:0] e;
        load_axis(FUNC_ROW, eff_rows);
        load_axis(FUNC_COL, eff_cols);
        for (int r = 0; r < eff_rows; r++)
            for (int c = 0; c < eff_cols; c++) begin
                case ($urandom_range(0, 9))
                    0:       e = 24'hFFFFFF;
                    1:       e = 24'd0;
                    default: e = 24'($urandom);
                endcase
                queue_word(FUNC_ENTRY, 3'(r), 3'(c), 16'($urandom), e,
                           16'($urandom), 16'($urandom));
            end
    endtask

    function automatic logic [15:0] pick_coord(input logic [15:0] p[8], int n);
        case ($urandom_range(0, 19))
            0, 1, 2:    return p[$urandom_range(0, n - 1)];
            3, 4, 5, 6: return 16'($urandom);
            default:    return 16'($urandom_range(p[0], p[n-1]));
        endcase
    endfunction

    task automatic random_words(int count);
        int k;
        for (int w = 0; w < count; w++) begin
            case ($urandom_range(0, 19))
                0: begin
                    // rewrite a point with any value; order may break
                    k = $urandom_range(0, 7);
                    write_point($urandom_range(0, 1) ? FUNC_ROW : FUNC_COL, k,
                                16'($urandom));
                end
                1, 2, 3:
                    queue_word(FUNC_ENTRY, 3'($urandom), 3'($urandom), 16'($urandom),
                               24'($urandom), 16'($urandom), 16'($urandom));
                default: query(pick_coord(plan_row, eff_rows), pick_coord(plan_col, eff_cols));
            endcase
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default 8x8, grid extremes and zero-width brackets
        for (int k = 0; k < 8; k++) begin
            write_point(FUNC_ROW, k, (k == 7) ? 16'hFFFF : 16'(k * 1000));
            write_point(FUNC_COL, k, (k == 0) ? 16'd0 : (k == 7) ? 16'hFFFF :
                        (k == 3) ? 16'd2000 : 16'(k * 1000));
        end
        for (int r = 0; r < 8; r++)
            for (int c = 0; c < 8; c++)
                queue_word(FUNC_ENTRY, 3'(r), 3'(c), 16'($urandom),
                           ((r + c) % 3 == 0) ? 24'hFFFFFF : 24'($urandom),
                           16'($urandom), 16'($urandom));
        query(16'd0, 16'd0);
        query(16'd3000, 16'd2000);
        query(16'hFFFF, 16'hFFFF);
        query(16'd1500, 16'd2500);
        query(16'd2000, 16'd2000);
        query(16'd6999, 16'd40000);
        query(16'd100, 16'd65534);

        // strictly decreasing pair breaks the row axis
        write_point(FUNC_ROW, 1, 16'd500);
        write_point(FUNC_ROW, 0, 16'd900);
        query(16'd700, 16'd100);
        query(16'd1200, 16'd100);
        write_point(FUNC_ROW, 0, 16'd200);
        query(16'd200, 16'd100);

        set_counts(4'd0, 4'd15);
        query(16'd500, 16'd70);
        query(16'd1200, 16'd100);
        set_counts(4'd2, 4'd2);
        query(16'd300, 16'd500);
        query(16'd600, 16'd500);

        no_gaps = 0;
        load_table();
        random_words(150);
        set_counts(4'd3, 4'd5);
        load_table();
        random_words(150);
        set_counts(4'd15, 4'd1);
        no_gaps = 1;
        load_table();
        random_words(150);
        set_counts(4'd8, 4'd8);
        no_gaps = 0;
        load_table();
        random_words(200);
        set_counts(4'd2, 4'd8);
        load_table();
        random_words(150);

        wait_idle();
        repeat (100) @(posedge i_clk);
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
